[hw/rtl/ssa_pkg.sv]
// Shared sizes, request codes and status codes of the session slot allocator.
package ssa_pkg;

    localparam int SLOTS        = 64;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CONTEXT_BITS = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int CFG_W        = 7;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(SLOTS);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_GET      = 3'd2,
        REQ_ACQUIRE  = 3'd3,
        REQ_RELEASE  = 3'd4,
        REQ_INACTIVE = 3'd5,
        REQ_READ     = 3'd6,
        REQ_NONE     = 3'd7
    } t_req_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_LOCKED = 2'd2,
        ST_RANGE  = 2'd3
    } t_status_e;

endpackage

[hw/rtl/ssa_req_if.sv]
// Request channel interface of the session slot allocator.
interface ssa_req_if;
    logic                               valid;
    logic                               ready;
    logic [ssa_pkg::REQ_W-1:0]          req_type;
    logic [ssa_pkg::IDX_W-1:0]          slot_index;
    logic [ssa_pkg::CONTEXT_BITS-1:0]   context_req;
    logic                               free_hook;

    modport source (output valid, req_type, slot_index, context_req, free_hook,
                    input ready);
    modport sink   (input valid, req_type, slot_index, context_req, free_hook,
                    output ready);
endinterface

[hw/rtl/ssa_rsp_if.sv]
// Response channel interface of the session slot allocator.
interface ssa_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ssa_pkg::STATUS_W-1:0]       status;
    logic [ssa_pkg::IDX_W-1:0]          result_index;
    logic [ssa_pkg::CONTEXT_BITS-1:0]   context_out;
    logic                               in_use;
    logic                               call_free;

    modport source (output valid, status, result_index, context_out, in_use, call_free,
                    input ready);
    modport sink   (input valid, status, result_index, context_out, in_use, call_free,
                    output ready);
endinterface

[hw/rtl/session_slot_allocator.sv]
// Session slot table with next-fit allocation, lock, context and free-hook handling.
// One request is handled at a time; ready is high only while the sequencer is idle, and
// a finished response waits in the output register without blocking the next request.
// Addressed requests (remove, get, acquire, release, mark inactive, read mark) are
// accepted, have their index checked and then read the context memory; an index out of
// range or the unused request code ends after the check.
// Insert is accepted, then count subtractions bring a stale search start below the active
// slot count, a further pass finds the start in range, and one to the active count of
// slots are scanned; one slot is examined per cycle by a single pointer increment and wrap
// compare. Any finishing step waits while the output is stalled. Per-slot flags
// live in flops that reset clears at once, so no clearing pass follows reset.
module session_slot_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ssa_pkg::CFG_W-1:0]  i_cfg_wdata,
    ssa_req_if.sink                    i_req,
    ssa_rsp_if.source                  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SCAN,
        S_CHECK,
        S_EXEC
    } t_state_e;

    t_state_e                          r_state;
    logic [ssa_pkg::CFG_W-1:0]         r_active;
    logic [ssa_pkg::IDX_W-1:0]         r_next_start;

    logic [ssa_pkg::SLOTS-1:0]         r_used;
    logic [ssa_pkg::SLOTS-1:0]         r_locked;
    logic [ssa_pkg::SLOTS-1:0]         r_hook;
    logic [ssa_pkg::SLOTS-1:0]         r_ctx_valid;
    logic [ssa_pkg::CONTEXT_BITS-1:0]  r_ctx_mem [ssa_pkg::SLOTS];
    logic [ssa_pkg::CONTEXT_BITS-1:0]  r_rd_data;

    ssa_pkg::t_req_e                   r_req;
    logic [ssa_pkg::IDX_W-1:0]         r_idx;
    logic [ssa_pkg::CONTEXT_BITS-1:0]  r_ctx;
    logic                              r_new_hook;
    logic [ssa_pkg::IDX_W-1:0]         r_pos;
    logic [ssa_pkg::CNT_W-1:0]         r_cnt;

    logic                              r_out_valid;
    ssa_pkg::t_status_e                r_status;
    logic [ssa_pkg::IDX_W-1:0]         r_res_idx;
    logic [ssa_pkg::CONTEXT_BITS-1:0]  r_ctx_out;
    logic                              r_in_use;
    logic                              r_call_free;

    logic [ssa_pkg::CFG_W-1:0]         w_count;
    logic [ssa_pkg::CNT_W-1:0]         w_pos_inc;
    logic                              w_pos_wrap;
    logic [ssa_pkg::IDX_W-1:0]         n_pos;
    logic                              w_out_free;
    logic                              w_slot_free;
    logic                              w_idx_bad;
    logic                              w_mem_we;
    logic [ssa_pkg::CONTEXT_BITS-1:0]  w_ctx_rd;

    // Clamp the active count to 1..SLOTS.
    always_comb begin
        if (r_active == '0) begin
            w_count = ssa_pkg::CFG_W'(1);
        end else if (r_active > ssa_pkg::CFG_W'(ssa_pkg::SLOTS)) begin
            w_count = ssa_pkg::CFG_W'(ssa_pkg::SLOTS);
        end else begin
            w_count = r_active;
        end
    end

    // Shared pointer unit: increment and wrap at the active count.
    assign w_pos_inc   = {1'b0, r_pos} + ssa_pkg::CNT_W'(1);
    assign w_pos_wrap  = (ssa_pkg::CFG_W'(w_pos_inc) == w_count);
    assign n_pos       = w_pos_wrap ? '0 : w_pos_inc[ssa_pkg::IDX_W-1:0];

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_slot_free = !r_locked[r_pos] && !r_used[r_pos];
    assign w_idx_bad   = (ssa_pkg::CFG_W'(r_idx) >= w_count);
    assign w_mem_we    = (r_state == S_SCAN) && w_slot_free && w_out_free;
    assign w_ctx_rd    = r_ctx_valid[r_idx] ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ctx_mem[r_pos] <= r_ctx;
        end
        r_rd_data <= r_ctx_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= ssa_pkg::ACTIVE_RESET;
            r_next_start <= '0;
            r_used       <= '0;
            r_locked     <= '0;
            r_hook       <= '0;
            r_ctx_valid  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req      <= ssa_pkg::t_req_e'(i_req.req_type);
                        r_idx      <= i_req.slot_index;
                        r_ctx      <= i_req.context_req;
                        r_new_hook <= i_req.free_hook;
                        r_pos      <= r_next_start;
                        r_cnt      <= '0;
                        if (ssa_pkg::t_req_e'(i_req.req_type) == ssa_pkg::REQ_INSERT) begin
                            r_state <= S_NORM;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end

                // Bring a stale start below the count by repeated subtraction.
                S_NORM: begin
                    if (ssa_pkg::CFG_W'(r_pos) >= w_count) begin
                        r_pos <= r_pos - w_count[ssa_pkg::IDX_W-1:0];
                    end else begin
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (w_slot_free) begin
                        if (w_out_free) begin
                            r_used[r_pos]      <= 1'b1;
                            r_ctx_valid[r_pos] <= 1'b1;
                            r_hook[r_pos]      <= r_new_hook;
                            r_next_start       <= n_pos;
                            r_out_valid        <= 1'b1;
                            r_status           <= ssa_pkg::ST_OK;
                            r_res_idx          <= r_pos;
                            r_ctx_out          <= '0;
                            r_in_use           <= 1'b1;
                            r_call_free        <= 1'b0;
                            r_state            <= S_IDLE;
                        end
                    end else if (ssa_pkg::CFG_W'(r_cnt) + ssa_pkg::CFG_W'(1) == w_count) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_status    <= ssa_pkg::ST_FULL;
                            r_res_idx   <= '0;
                            r_ctx_out   <= '0;
                            r_in_use    <= 1'b0;
                            r_call_free <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_pos <= n_pos;
                        r_cnt <= r_cnt + ssa_pkg::CNT_W'(1);
                    end
                end

                S_CHECK: begin
                    if (r_req == ssa_pkg::REQ_NONE || w_idx_bad) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_status    <= (r_req == ssa_pkg::REQ_NONE) ? ssa_pkg::ST_OK
                                                                      : ssa_pkg::ST_RANGE;
                            r_res_idx   <= r_idx;
                            r_ctx_out   <= '0;
                            r_in_use    <= 1'b0;
                            r_call_free <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_res_idx   <= r_idx;
                        r_status    <= ssa_pkg::ST_OK;
                        r_ctx_out   <= '0;
                        r_in_use    <= r_used[r_idx];
                        r_call_free <= 1'b0;
                        r_state     <= S_IDLE;
                        unique case (r_req)
                            ssa_pkg::REQ_REMOVE: begin
                                r_ctx_out          <= w_ctx_rd;
                                r_call_free        <= r_hook[r_idx];
                                r_in_use           <= 1'b0;
                                r_used[r_idx]      <= 1'b0;
                                r_ctx_valid[r_idx] <= 1'b0;
                                r_hook[r_idx]      <= 1'b0;
                            end
                            ssa_pkg::REQ_GET: begin
                                r_ctx_out <= w_ctx_rd;
                            end
                            ssa_pkg::REQ_ACQUIRE: begin
                                if (r_locked[r_idx]) begin
                                    r_status <= ssa_pkg::ST_LOCKED;
                                end else begin
                                    r_locked[r_idx] <= 1'b1;
                                    r_ctx_out       <= w_ctx_rd;
                                end
                            end
                            ssa_pkg::REQ_RELEASE: begin
                                r_locked[r_idx] <= 1'b0;
                            end
                            ssa_pkg::REQ_INACTIVE: begin
                                r_used[r_idx] <= 1'b0;
                                r_in_use      <= 1'b0;
                            end
                            default: begin
                                // read mark: report only
                            end
                        endcase
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.result_index = r_res_idx;
    assign o_rsp.context_out  = r_ctx_out;
    assign o_rsp.in_use       = r_in_use;
    assign o_rsp.call_free    = r_call_free;

`ifndef ASSERT_OFF
    a_scan_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (ssa_pkg::CFG_W'(r_pos) < w_count))
        else $error("scan pointer beyond active slot count");

    a_scan_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (ssa_pkg::CFG_W'(r_cnt) < w_count))
        else $error("scan examined more slots than active");

    a_grant_marks_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> (r_used[$past(r_pos)] && r_out_valid && r_res_idx == $past(r_pos)))
        else $error("granted slot not marked in use");

    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_out_free && r_req == ssa_pkg::REQ_REMOVE)
        |=> (!r_used[$past(r_idx)] && !r_ctx_valid[$past(r_idx)]))
        else $error("removed slot still holds state");
`endif

endmodule
